[hdl/button_debounce_autorepeat_assert.svh]
// Assertion macros for the button debounce and auto-repeat block.
// Used by the top level, which must provide clk and rst_n in scope.
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_ASSERT_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bda_pkg.sv]
// Shared types and constants for the button debounce and auto-repeat block.
// No dependencies; imported by bda_button, button_debounce_autorepeat, bda_checker and tb.
`timescale 1ns / 1ps

package bda_pkg;

  localparam int FIELD_W   = 5;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int NUM_BUTTONS_DEF = 5;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd50;
  localparam logic [CFG_W-1:0] REPEAT_DELAY_RST = 16'd500;
  localparam logic [CFG_W-1:0] REPEAT_RATE_RST  = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE     = 2'd0,
    CFG_REPEAT_DELAY = 2'd1,
    CFG_REPEAT_RATE  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_PRESS_DB   = 2'd1,
    PH_HELD       = 2'd2,
    PH_RELEASE_DB = 2'd3
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] repeat_delay_ms;
    logic [CFG_W-1:0] repeat_rate_ms;
  } bda_cfg_t;

  typedef struct packed {
    logic press;
    logic held;
    logic rep;
  } bda_flags_t;

endpackage

[hdl/button_debounce_autorepeat.sv]
// Top level of the button debounce and auto-repeat block: handshakes, config
// registers, input and result registers. Depends on bda_pkg, bda_button and the assertion header.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+---------------------------------
//   in_      | input     | in_valid / in_stall | now_ms, raw_pressed, rearm_mask
//   out_     | output    | out_valid/out_stall | press_pulse, held_level, repeat_pulse
//   cfg_     | input     | cfg_wr_en           | cfg_addr, cfg_wdata
//
// An item is captured in the input register, where all buttons update in
// parallel with one subtract-and-compare per timer, and then sits in the result
// register: one item per cycle sustained while the output is not stalled.
// Synchronous active-low reset clears both valid flags, all button phases and
// loads the timing registers with 50, 500 and 100 ms. A stall on the result side
// holds the result and stalls the input only once both registers are full.
`timescale 1ns / 1ps

module button_debounce_autorepeat #(
  parameter int NUM_BUTTONS = bda_pkg::NUM_BUTTONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bda_pkg::TIME_W-1:0]    in_now_ms,
  input  logic [bda_pkg::FIELD_W-1:0]   in_raw_pressed,
  input  logic [bda_pkg::FIELD_W-1:0]   in_rearm_mask,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bda_pkg::FIELD_W-1:0]   out_press_pulse,
  output logic [bda_pkg::FIELD_W-1:0]   out_held_level,
  output logic [bda_pkg::FIELD_W-1:0]   out_repeat_pulse,
  input  logic                          cfg_wr_en,
  input  logic [bda_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [bda_pkg::CFG_W-1:0]     cfg_wdata
);
  import bda_pkg::*;

  bda_cfg_t            cfg_r;

  logic                s1_valid_r;
  logic [TIME_W-1:0]   s1_now_r;
  logic [FIELD_W-1:0]  s1_raw_r;
  logic [FIELD_W-1:0]  s1_rearm_r;

  logic                out_valid_r;
  logic [FIELD_W-1:0]  press_r, held_r, rep_r;

  logic                advance;
  logic                in_take;
  bda_flags_t          flags_v [NUM_BUTTONS];
  logic [FIELD_W-1:0]  press_f, held_f, rep_f;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms     <= DEBOUNCE_RST;
      cfg_r.repeat_delay_ms <= REPEAT_DELAY_RST;
      cfg_r.repeat_rate_ms  <= REPEAT_RATE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_DEBOUNCE:     cfg_r.debounce_ms     <= cfg_wdata;
        CFG_REPEAT_DELAY: cfg_r.repeat_delay_ms <= cfg_wdata;
        CFG_REPEAT_RATE:  cfg_r.repeat_rate_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now_r   <= in_now_ms;
      s1_raw_r   <= in_raw_pressed;
      s1_rearm_r <= in_rearm_mask;
    end
    if (advance) begin
      press_r <= press_f;
      held_r  <= held_f;
      rep_r   <= rep_f;
    end
  end

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    logic raw_bit, rearm_bit;
    // Buttons past the field width see no press and never show up.
    if (b < FIELD_W) begin : g_in
      assign raw_bit   = s1_raw_r[b];
      assign rearm_bit = s1_rearm_r[b];
    end else begin : g_none
      assign raw_bit   = 1'b0;
      assign rearm_bit = 1'b0;
    end
    bda_button u_btn (
      .clk     (clk),
      .rst_n   (rst_n),
      .upd     (advance),
      .now_ms  (s1_now_r),
      .pressed (raw_bit),
      .rearm   (rearm_bit),
      .cfg     (cfg_r),
      .flags   (flags_v[b])
    );
  end

  for (genvar j = 0; j < FIELD_W; j++) begin : g_out
    if (j < NUM_BUTTONS) begin : g_used
      assign press_f[j] = flags_v[j].press;
      assign held_f[j]  = flags_v[j].held;
      assign rep_f[j]   = flags_v[j].rep;
    end else begin : g_unused
      assign press_f[j] = 1'b0;
      assign held_f[j]  = 1'b0;
      assign rep_f[j]   = 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_press_pulse  = press_r;
  assign out_held_level   = held_r;
  assign out_repeat_pulse = rep_r;

`include "button_debounce_autorepeat_assert.svh"

  `BDA_ASSERT_NOW(a_press_held, out_valid_r, (press_r & ~held_r) == '0, "press without held level")
  `BDA_ASSERT_NOW(a_rep_held, out_valid_r, (rep_r & ~held_r) == '0, "repeat without held level")
  `BDA_ASSERT_NEXT(a_s1_moves, s1_valid_r && !out_valid_r, out_valid_r, "item not forwarded")
  `BDA_ASSERT_NEXT(a_out_holds, out_valid_r && out_stall, out_valid_r && $stable(held_r), "result dropped")

endmodule

[hdl/bda_button.sv]
// Per-button debounce state machine with hold timer and auto-repeat.
// Depends on bda_pkg for the phase type, the timing struct and the flag struct.
`timescale 1ns / 1ps

module bda_button (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       upd,
  input  logic [bda_pkg::TIME_W-1:0] now_ms,
  input  logic                       pressed,
  input  logic                       rearm,
  input  bda_pkg::bda_cfg_t          cfg,
  output bda_pkg::bda_flags_t        flags
);
  import bda_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic                armed_r, armed_nxt;
  logic [TIME_W-1:0]   chg_time_r, chg_time_nxt;
  logic [TIME_W-1:0]   hold_start_r, hold_start_nxt;
  logic [TIME_W-1:0]   last_rep_r, last_rep_nxt;

  logic [TIME_W-1:0]   hold_base;
  logic                db_done;
  logic                press_now;
  logic                held_nxt;
  logic                arm_now;
  logic                rep_due;

  assign db_done = (now_ms - chg_time_r) >= TIME_W'(cfg.debounce_ms);

  always_comb begin
    phase_nxt    = phase_r;
    chg_time_nxt = chg_time_r;
    hold_base    = hold_start_r;
    press_now    = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (pressed) begin
          phase_nxt    = PH_PRESS_DB;
          chg_time_nxt = now_ms;
        end
      end
      PH_PRESS_DB: begin
        if (!pressed) begin
          phase_nxt = PH_IDLE;
        end else if (db_done) begin
          phase_nxt = PH_HELD;
          press_now = 1'b1;
          hold_base = now_ms;
        end
      end
      PH_HELD: begin
        if (!pressed) begin
          phase_nxt    = PH_RELEASE_DB;
          chg_time_nxt = now_ms;
        end
      end
      PH_RELEASE_DB: begin
        // A press during release debounce returns to held; the hold time is kept.
        if (pressed) begin
          phase_nxt = PH_HELD;
        end else if (db_done) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  assign held_nxt = (phase_nxt == PH_HELD) || (phase_nxt == PH_RELEASE_DB);
  assign arm_now  = !armed_r && ((now_ms - hold_base) >= TIME_W'(cfg.repeat_delay_ms));
  // Arming stamps the repeat time with now, so it fires at once only for a zero rate.
  assign rep_due  = armed_r ? ((now_ms - last_rep_r) >= TIME_W'(cfg.repeat_rate_ms))
                            : (arm_now && (cfg.repeat_rate_ms == '0));

  always_comb begin
    armed_nxt      = 1'b0;
    last_rep_nxt   = last_rep_r;
    hold_start_nxt = hold_base;
    flags.press    = press_now;
    flags.held     = held_nxt;
    flags.rep      = 1'b0;
    if (held_nxt) begin
      armed_nxt = armed_r || arm_now;
      flags.rep = rep_due;
      if (arm_now || rep_due) begin
        last_rep_nxt = now_ms;
      end
      if (rearm) begin
        hold_start_nxt = now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      armed_r <= 1'b0;
    end else if (upd) begin
      phase_r <= phase_nxt;
      armed_r <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      chg_time_r   <= chg_time_nxt;
      hold_start_r <= hold_start_nxt;
      last_rep_r   <= last_rep_nxt;
    end
  end

endmodule

[bench/bda_checker.sv]
// Checker for the button debounce and auto-repeat block: tracks config writes,
// predicts one result per accepted item and compares results in order.
// Depends on bda_pkg.
`timescale 1ns / 1ps

module bda_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [bda_pkg::TIME_W-1:0]    in_now_ms,
  input  logic [bda_pkg::FIELD_W-1:0]   in_raw_pressed,
  input  logic [bda_pkg::FIELD_W-1:0]   in_rearm_mask,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [bda_pkg::FIELD_W-1:0]   out_press_pulse,
  input  logic [bda_pkg::FIELD_W-1:0]   out_held_level,
  input  logic [bda_pkg::FIELD_W-1:0]   out_repeat_pulse,
  input  logic                          cfg_wr_en,
  input  logic [bda_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [bda_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            pending_count
);
  import bda_pkg::*;

  localparam int NB = NUM_BUTTONS_DEF;

  typedef struct packed {
    logic [FIELD_W-1:0] press;
    logic [FIELD_W-1:0] held;
    logic [FIELD_W-1:0] rpt;
  } button_result_t;

  logic [CFG_W-1:0]  debounce_ms;
  logic [CFG_W-1:0]  delay_ms;
  logic [CFG_W-1:0]  rate_ms;

  phase_t            btn_phase   [NB];
  logic              held_q      [NB];
  logic [TIME_W-1:0] phase_since [NB];
  logic [TIME_W-1:0] hold_from   [NB];
  logic              armed       [NB];
  logic [TIME_W-1:0] last_rpt    [NB];

  button_result_t    expected_results[$];

  function automatic logic [TIME_W-1:0] since_ms(logic [TIME_W-1:0] now,
                                                 logic [TIME_W-1:0] then_ms);
    return now - then_ms;
  endfunction

  // Advances every button by one update and returns what the block reports.
  function automatic button_result_t update_buttons(logic [TIME_W-1:0] now,
                                                    logic [FIELD_W-1:0] raw,
                                                    logic [FIELD_W-1:0] rearm);
    button_result_t r;
    r = '0;
    for (int b = 0; b < NB; b++) begin
      case (btn_phase[b])
        PH_IDLE: begin
          if (raw[b]) begin
            btn_phase[b]   = PH_PRESS_DB;
            phase_since[b] = now;
          end
        end
        PH_PRESS_DB: begin
          if (!raw[b]) begin
            btn_phase[b] = PH_IDLE;
          end else if (since_ms(now, phase_since[b]) >= {16'h0, debounce_ms}) begin
            btn_phase[b] = PH_HELD;
            held_q[b]    = 1'b1;
            r.press[b]   = 1'b1;
            hold_from[b] = now;
          end
        end
        PH_HELD: begin
          if (!raw[b]) begin
            btn_phase[b]   = PH_RELEASE_DB;
            phase_since[b] = now;
          end
        end
        default: begin
          // A press seen while releasing goes back to held with the hold time kept.
          if (raw[b]) begin
            btn_phase[b] = PH_HELD;
          end else if (since_ms(now, phase_since[b]) >= {16'h0, debounce_ms}) begin
            btn_phase[b] = PH_IDLE;
            held_q[b]    = 1'b0;
          end
        end
      endcase

      if (!held_q[b]) begin
        armed[b] = 1'b0;
      end else begin
        if (!armed[b] && since_ms(now, hold_from[b]) >= {16'h0, delay_ms}) begin
          armed[b]    = 1'b1;
          last_rpt[b] = now;
        end
        if (armed[b] && since_ms(now, last_rpt[b]) >= {16'h0, rate_ms}) begin
          last_rpt[b] = now;
          r.rpt[b]    = 1'b1;
        end
        r.held[b] = 1'b1;
        if (rearm[b]) begin
          hold_from[b] = now;
        end
      end
    end
    return r;
  endfunction

  task automatic report(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    button_result_t got;
    button_result_t want;
    if (!rst_n) begin
      debounce_ms = DEBOUNCE_RST;
      delay_ms    = REPEAT_DELAY_RST;
      rate_ms     = REPEAT_RATE_RST;
      for (int b = 0; b < NB; b++) begin
        btn_phase[b]   = PH_IDLE;
        held_q[b]      = 1'b0;
        phase_since[b] = '0;
        hold_from[b]   = '0;
        armed[b]       = 1'b0;
        last_rpt[b]    = '0;
      end
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{press: out_press_pulse, held: out_held_level, rpt: out_repeat_pulse};
        if (expected_results.size() == 0) begin
          report($sformatf("result %p arrived with no item outstanding", got));
        end else begin
          want = expected_results.pop_front();
          if (got.press !== want.press)
            report($sformatf("press_pulse expected %b got %b", want.press, got.press));
          if (got.held !== want.held)
            report($sformatf("held_level expected %b got %b", want.held, got.held));
          if (got.rpt !== want.rpt)
            report($sformatf("repeat_pulse expected %b got %b", want.rpt, got.rpt));
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(update_buttons(in_now_ms, in_raw_pressed,
                                                  in_rearm_mask));
      end
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_DEBOUNCE:     debounce_ms = cfg_wdata;
          CFG_REPEAT_DELAY: delay_ms    = cfg_wdata;
          CFG_REPEAT_RATE:  rate_ms     = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending_count = expected_results.size();
  end

endmodule

[bench/tb.sv]
// Top-level testbench for button_debounce_autorepeat: clock, reset, timing
// register writes, item stimulus with random pacing and the final verdict.
// Depends on bda_pkg, button_debounce_autorepeat and bda_checker.
`timescale 1ns / 1ps

module tb;
  import bda_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TIME_W-1:0]    in_now_ms = '0;
  logic [FIELD_W-1:0]   in_raw_pressed = '0;
  logic [FIELD_W-1:0]   in_rearm_mask = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [FIELD_W-1:0]   out_press_pulse;
  logic [FIELD_W-1:0]   out_held_level;
  logic [FIELD_W-1:0]   out_repeat_pulse;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  int                   fail_count;
  int                   pending_count;
  int                   burst_left = 0;

  always #5 clk = ~clk;

  button_debounce_autorepeat u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_now_ms        (in_now_ms),
    .in_raw_pressed   (in_raw_pressed),
    .in_rearm_mask    (in_rearm_mask),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_press_pulse  (out_press_pulse),
    .out_held_level   (out_held_level),
    .out_repeat_pulse (out_repeat_pulse),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  bda_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_now_ms        (in_now_ms),
    .in_raw_pressed   (in_raw_pressed),
    .in_rearm_mask    (in_rearm_mask),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_press_pulse  (out_press_pulse),
    .out_held_level   (out_held_level),
    .out_repeat_pulse (out_repeat_pulse),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending_count    (pending_count)
  );

  function automatic bit chance(int percent);
    return $urandom_range(0, 99) < percent;
  endfunction

  // Mostly back-to-back items, some short gaps, a few long ones, and now and
  // then a burst with no gaps at all.
  function automatic int pick_gap();
    int sel;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      burst_left = $urandom_range(30, 100);
      return 0;
    end
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Called right after a rising edge; returns at the edge that accepts the item.
  task automatic send_item(input logic [TIME_W-1:0] now, input logic [FIELD_W-1:0] raw,
                           input logic [FIELD_W-1:0] rearm);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_now_ms      <= now;
    in_raw_pressed <= raw;
    in_rearm_mask  <= rearm;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until every outstanding item has produced its result.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] delay,
                            input logic [CFG_W-1:0] rate);
    drain();
    write_reg(CFG_DEBOUNCE, debounce);
    write_reg(CFG_REPEAT_DELAY, delay);
    write_reg(CFG_REPEAT_RATE, rate);
    cfg_wr_en <= 1'b0;
  endtask

  // Time moves forward in random steps while each button follows a slowly
  // changing intended level with contact bounce on top; a few items are noise.
  task automatic run_presses(input int count, input int max_step,
                             input logic [TIME_W-1:0] start);
    logic [TIME_W-1:0]  cur_time;
    logic [FIELD_W-1:0] intent;
    logic [FIELD_W-1:0] bounce;
    logic [FIELD_W-1:0] rearm;
    cur_time = start;
    intent   = '0;
    for (int k = 0; k < count; k++) begin
      if (chance(7)) begin
        send_item($urandom, FIELD_W'($urandom_range(0, 31)), FIELD_W'($urandom_range(0, 31)));
      end else begin
        if (chance(4))
          cur_time += $urandom_range(0, 4 * max_step);
        else
          cur_time += $urandom_range(0, max_step);
        bounce = '0;
        for (int b = 0; b < FIELD_W; b++) begin
          if (chance(5)) intent[b] = ~intent[b];
          if (chance(8)) bounce[b] = 1'b1;
        end
        rearm = chance(15) ? FIELD_W'($urandom_range(1, 31)) : '0;
        send_item(cur_time, intent ^ bounce, rearm);
      end
    end
  endtask

  initial begin : sink_pacing
    int sel;
    int run_len;
    logic hold;
    forever begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        hold    = 1'b0;
        run_len = $urandom_range(1, 12);
      end else if (sel < 85) begin
        hold    = 1'b1;
        run_len = $urandom_range(1, 3);
      end else if (sel < 95) begin
        hold    = 1'b0;
        run_len = $urandom_range(40, 120);
      end else begin
        hold    = 1'b1;
        run_len = $urandom_range(15, 50);
      end
      repeat (run_len) begin
        @(posedge clk);
        out_stall <= hold;
      end
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sequence on the reset timing (50 / 500 / 100 ms).
    send_item(32'd0, 5'h00, 5'h00);
    send_item(32'd10, 5'h1F, 5'h00);
    send_item(32'd30, 5'h0F, 5'h00);  // button 4 bounces back to idle
    send_item(32'd60, 5'h1F, 5'h00);  // buttons 0-3 accepted
    send_item(32'd110, 5'h1F, 5'h1F);
    send_item(32'd300, 5'h1E, 5'h00);
    send_item(32'd320, 5'h1F, 5'h00); // release bounce returns to held
    send_item(32'd610, 5'h1F, 5'h02);
    send_item(32'd710, 5'h1F, 5'h00);
    send_item(32'd760, 5'h1F, 5'h00);
    send_item(32'd810, 5'h1F, 5'h00);
    send_item(32'd850, 5'h00, 5'h1F);
    send_item(32'd900, 5'h00, 5'h00);
    send_item(32'd901, 5'h00, 5'h1F); // rearm with nothing held
    send_item(32'hFFFF_FFF0, 5'h01, 5'h00);
    send_item(32'h0000_0020, 5'h01, 5'h00);
    send_item(32'h0000_0022, 5'h01, 5'h1F);
    send_item(32'hFFFF_FFFF, 5'h1F, 5'h1F);
    send_item(32'hFFFF_FFFF, 5'h00, 5'h00);
    send_item(32'h0000_0000, 5'h00, 5'h00);

    run_presses(400, 30, 32'd1000);
    set_timing(16'd6, 16'd25, 16'd5);
    run_presses(350, 4, 32'hFFFF_FF00);
    set_timing(16'd0, 16'd0, 16'd0);
    run_presses(200, 3, $urandom);
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_presses(300, 20000, 32'hFFF0_0000);
    set_timing(CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(0, 1000)),
               CFG_W'($urandom_range(0, 200)));
    run_presses(200, 40, $urandom);
    set_timing(CFG_W'($urandom_range(0, 20)), CFG_W'($urandom_range(0, 100)),
               CFG_W'($urandom_range(0, 20)));
    run_presses(200, 8, $urandom);

    drain();
    if (fail_count == 0)
      $display("button_debounce_autorepeat test passed");
    else
      $display("button_debounce_autorepeat test failed");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("button_debounce_autorepeat test failed");
    $finish;
  end

endmodule
